/* src/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the packet segment deframer
// Item structs for the byte input and the segment result, plus the header sizes.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam logic [15:0] HEADER_BYTES  = 16'd12;
	localparam logic [15:0] SEG_HDR_BYTES = 16'd8;

	typedef struct packed {
		logic [7:0]  pkt_byte;
		logic        first_of_packet;
		logic [15:0] packet_length;
	} in_item_t;

	typedef struct packed {
		logic [31:0] segment_command;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} out_item_t;

endpackage

/* src/packet_segment_deframer_top.sv */
// An accepted byte goes through the input register, then the result register, to out_valid.
// One byte per cycle unless the output stalls; parse state updates once per byte.
// A result held in the output register stalls the input stage only when it is not taken.
// Reset (arst_n low) clears both stage valids and the parse state; the held packet
// length is 0, so bytes before the first start-of-packet byte are ignored.
// ----------------------------------------------------------------------------
// packet_segment_deframer_top: length-prefixed segment parser
// Walks the segments of a byte-serial packet and emits command, offset and length.
// ----------------------------------------------------------------------------
module packet_segment_deframer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  psd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output psd_pkg::out_item_t out_data
);

	logic               valid_s1;
	psd_pkg::in_item_t  item_s1;
	logic               adv;
	logic               out_free;
	logic               res_valid;
	psd_pkg::out_item_t res;

	// advance the input stage only when a result has somewhere to go
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	psd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	psd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res_valid),
		.din       (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* src/psd_parse.sv */
// ----------------------------------------------------------------------------
// psd_parse: segment walker
// Holds the per-packet parse state and handles one byte per enabled cycle.
// ----------------------------------------------------------------------------
module psd_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  psd_pkg::in_item_t  item,
	output logic               res_valid,
	output psd_pkg::out_item_t res
);

	logic [15:0] pos_q, start_q, len_q, held_q;
	logic [31:0] cmd_q;
	logic        stop_q;

	logic [15:0] pos_c, start_c, len_c, held_c, rel;
	logic [31:0] cmd_c;
	logic        stop_c;
	logic        live, in_hdr, last_hdr, bad;
	logic [16:0] seg_end;

	logic [15:0] pos_n, start_n, len_n;
	logic [31:0] cmd_n;
	logic        stop_n;

	always_comb begin
		// a first byte restarts the parse before the byte itself is handled
		pos_c   = item.first_of_packet ? 16'd0 : pos_q;
		start_c = item.first_of_packet ? psd_pkg::HEADER_BYTES : start_q;
		len_c   = item.first_of_packet ? 16'd0 : len_q;
		cmd_c   = item.first_of_packet ? 32'd0 : cmd_q;
		held_c  = item.first_of_packet ? item.packet_length : held_q;
		stop_c  = item.first_of_packet ? 1'b0 : stop_q;

		live     = pos_c < held_c;
		rel      = pos_c - start_c;
		in_hdr   = live && !stop_c && (pos_c >= start_c) && (rel < psd_pkg::SEG_HDR_BYTES);
		last_hdr = in_hdr && (rel == psd_pkg::SEG_HDR_BYTES - 16'd1);
		seg_end  = {1'b0, start_c} + {1'b0, len_c};
		bad      = (len_c < psd_pkg::SEG_HDR_BYTES) || (seg_end > {1'b0, held_c});

		pos_n   = live ? pos_c + 16'd1 : pos_c;
		start_n = start_c;
		len_n   = len_c;
		cmd_n   = cmd_c;
		stop_n  = stop_c;

		if (in_hdr) begin
			if (rel == 16'd0) begin
				len_n = {item.pkt_byte, 8'd0};
			end else if (rel == 16'd1) begin
				len_n = {len_c[15:8], item.pkt_byte};
			end else if (rel >= 16'd4) begin
				cmd_n = {cmd_c[23:0], item.pkt_byte};
			end
		end

		res_valid           = last_hdr && !bad;
		res.segment_command = {cmd_c[23:0], item.pkt_byte};
		res.payload_offset  = start_c + psd_pkg::SEG_HDR_BYTES;
		res.payload_length  = len_c - psd_pkg::SEG_HDR_BYTES;

		if (last_hdr) begin
			if (bad) begin
				stop_n = 1'b1;
			end else begin
				start_n = seg_end[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 16'd0;
			start_q <= psd_pkg::HEADER_BYTES;
			len_q   <= 16'd0;
			cmd_q   <= 32'd0;
			held_q  <= 16'd0;
			stop_q  <= 1'b0;
		end else if (en) begin
			pos_q   <= pos_n;
			start_q <= start_n;
			len_q   <= len_n;
			cmd_q   <= cmd_n;
			held_q  <= held_c;
			stop_q  <= stop_n;
		end
	end

endmodule

/* src/psd_out_reg.sv */
// ----------------------------------------------------------------------------
// psd_out_reg: result register
// Holds one segment result until the downstream side takes it.
// ----------------------------------------------------------------------------
module psd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  psd_pkg::out_item_t din,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output psd_pkg::out_item_t out_data
);

	logic               valid_q;
	psd_pkg::out_item_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule
